>>> design/cpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpi_pkg;

  localparam int CPI_PALETTE_DEPTH = 256;
  localparam int CPI_COLOR_W       = 24;
  localparam int CPI_INDEX_W       = 8;
  localparam int CPI_USED_W        = 9;

  typedef enum logic [1:0] {
    CPI_IDLE,
    CPI_SCAN,
    CPI_DONE
  } cpi_state_t;

  // pixel handed from the input register to the search engine
  typedef struct packed {
    logic [CPI_COLOR_W-1:0] color;
    logic                   last;
  } cpi_req_t;

  // finished result, already cut to the output widths
  typedef struct packed {
    logic [CPI_INDEX_W-1:0] index;
    logic                   new_color;
    logic                   full;
    logic [CPI_USED_W-1:0]  used;
  } cpi_res_t;

endpackage

`default_nettype wire

>>> design/color_palette_indexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Word
// in_      in   in_valid/in_stall    red, green, blue, last_pixel
// out_     out  out_valid/out_stall  palette_index, new_color, palette_full, colors_used
//
// The search walks the palette RAM in insertion order, one read and one 24-bit compare
// per cycle, and stops at the first hit or after the last entry in use. Reset (rst_n
// low, synchronous) empties the palette; entries are not cleared, only those below the
// fill count are ever read. The next pixel waits in an input register during a search;
// a finished result waits in the output register, then in the search unit, while
// out_stall is high.

module color_palette_indexer
  import cpi_pkg::*;
#(
  parameter int PALETTE_DEPTH = CPI_PALETTE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic       in_last_pixel,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_palette_index,
  output logic            out_new_color,
  output logic            out_palette_full,
  output logic [8:0]      out_colors_used
);

  // input holding register
  logic     in_full_r, in_full_nxt;
  cpi_req_t in_req_r, in_req_nxt;
  logic     in_accept;
  logic     start;
  logic     req_ready;

  // result path
  logic     res_valid;
  cpi_res_t res;
  logic     res_take;
  logic     out_valid_r, out_valid_nxt;
  cpi_res_t out_r, out_nxt;

  assign in_stall  = in_full_r;
  assign in_accept = in_valid && !in_full_r;
  assign start     = in_full_r && req_ready;

  always_comb begin
    in_full_nxt = (in_full_r && !start) || in_accept;
    in_req_nxt  = in_req_r;
    if (in_accept) begin
      in_req_nxt.color = {in_red, in_green, in_blue};
      in_req_nxt.last  = in_last_pixel;
    end
  end

  cpi_search #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_full_r),
    .req      (in_req_r),
    .req_ready(req_ready),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  // output register loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = res_take || (out_valid_r && out_stall);
    out_nxt       = res_take ? res : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_req_r <= in_req_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_r.index;
  assign out_new_color     = out_r.new_color;
  assign out_palette_full  = out_r.full;
  assign out_colors_used   = out_r.used;

endmodule

`default_nettype wire

>>> design/cpi_search.sv
`timescale 1ns / 1ps
`default_nettype none

module cpi_search
  import cpi_pkg::*;
#(
  parameter int PALETTE_DEPTH = CPI_PALETTE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     req_valid,
  input  wire cpi_req_t req,
  output logic          req_ready,
  output logic          res_valid,
  output cpi_res_t      res,
  input  wire logic     res_take
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int XW = (IW > CPI_INDEX_W) ? IW : CPI_INDEX_W;
  localparam int UW = (CW > CPI_USED_W) ? CW : CPI_USED_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

  logic [CPI_COLOR_W-1:0] mem [PALETTE_DEPTH];

  cpi_state_t             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          rd_k_r, rd_k_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]          cmp_k_r, cmp_k_nxt;
  logic [CPI_COLOR_W-1:0] color_r, color_nxt;
  logic                   last_r, last_nxt;
  logic [CPI_COLOR_W-1:0] rdata_r;
  cpi_res_t               res_r, res_nxt;

  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic                   hit;
  logic                   scan_end;
  logic [XW-1:0]          idx_ext;
  logic [UW-1:0]          used_ext;

  // one compare per cycle against the entry read the cycle before
  assign hit      = cmp_vld_r && (rdata_r == color_r);
  assign rd_en    = (state_r == CPI_SCAN) && (rd_k_r < count_r);
  assign rd_addr  = rd_k_r[IW-1:0];
  assign scan_end = (state_r == CPI_SCAN) && (hit || !rd_en);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CPI_IDLE: if (req_valid) state_nxt = CPI_SCAN;
      CPI_SCAN: if (scan_end)  state_nxt = CPI_DONE;
      CPI_DONE: if (res_take)  state_nxt = CPI_IDLE;
      default:                 state_nxt = CPI_IDLE;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    rd_k_nxt    = rd_k_r;
    cmp_vld_nxt = 1'b0;
    cmp_k_nxt   = cmp_k_r;
    color_nxt   = color_r;
    last_nxt    = last_r;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[IW-1:0];
    idx_ext     = '0;
    used_ext    = UW'(count_r);
    req_ready   = (state_r == CPI_IDLE);
    res_valid   = (state_r == CPI_DONE);
    case (state_r)
      CPI_IDLE: begin
        if (req_valid) begin
          color_nxt = req.color;
          last_nxt  = req.last;
          rd_k_nxt  = '0;
        end
      end
      CPI_SCAN: begin
        if (rd_en) begin
          rd_k_nxt    = rd_k_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_k_nxt   = rd_k_r[IW-1:0];
        end
        if (hit) begin
          idx_ext           = XW'(cmp_k_r);
          res_nxt.index     = idx_ext[CPI_INDEX_W-1:0];
          res_nxt.new_color = 1'b0;
          res_nxt.full      = 1'b0;
          res_nxt.used      = used_ext[CPI_USED_W-1:0];
          if (last_r) count_nxt = '0;
        end else if (!rd_en) begin
          if (count_r < DEPTH_C) begin
            // append at the next free slot
            wr_en             = 1'b1;
            idx_ext           = XW'(count_r[IW-1:0]);
            used_ext          = UW'(count_r + 1'b1);
            res_nxt.index     = idx_ext[CPI_INDEX_W-1:0];
            res_nxt.new_color = 1'b1;
            res_nxt.full      = 1'b0;
            res_nxt.used      = used_ext[CPI_USED_W-1:0];
            count_nxt         = last_r ? '0 : count_r + 1'b1;
          end else begin
            res_nxt.index     = '0;
            res_nxt.new_color = 1'b0;
            res_nxt.full      = 1'b1;
            res_nxt.used      = used_ext[CPI_USED_W-1:0];
            if (last_r) count_nxt = '0;
          end
        end
      end
      CPI_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= color_r;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CPI_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r  <= rd_k_nxt;
    cmp_k_r <= cmp_k_nxt;
    color_r <= color_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

>>> tb/tb_color_palette_indexer.sv
`timescale 1ns / 1ps

// Palette indexer bench: pixels stream in as images, a scoreboard model of the
// palette predicts every result, and the result port is checked in order.
module tb_color_palette_indexer;
  import cpi_pkg::*;

  localparam int DEPTH        = CPI_PALETTE_DEPTH;
  localparam int TOTAL_PIXELS = 1400;
  // a full-palette search plus pipeline slack
  localparam int TAIL_CYCLES  = DEPTH + 64;

  // one pending input word; drain makes the driver wait for all results first
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    bit         drain;
  } pixel_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [7:0] in_red        = 8'h00;
  logic [7:0] in_green      = 8'h00;
  logic [7:0] in_blue       = 8'h00;
  logic       in_last_pixel = 1'b0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [7:0] out_palette_index;
  logic       out_new_color;
  logic       out_palette_full;
  logic [8:0] out_colors_used;

  always #5 clk = ~clk;

  color_palette_indexer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_last_pixel    (in_last_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_palette_index(out_palette_index),
    .out_new_color    (out_new_color),
    .out_palette_full (out_palette_full),
    .out_colors_used  (out_colors_used)
  );

  pixel_t     pending_q[$];   // stimulus not yet handed to the DUT
  cpi_res_t   due_q[$];       // predicted results, oldest first

  // scoreboard copy of the palette
  logic [23:0] pal_mem [DEPTH];
  int          pal_used = 0;

  int n_errors    = 0;
  int n_pixels    = 0;
  int n_images    = 0;
  int n_results   = 0;
  int n_hits      = 0;
  int n_new       = 0;
  int n_full      = 0;
  int peak_used   = 0;
  int pushed      = 0;

  logic px_taken = 1'b0;      // input word accepted at the last rising edge

  // ---------------------------------------------------------------------------
  // Palette model: linear search in insertion order, append on a miss, flag
  // full when there is no room, empty the palette after a last pixel.
  // ---------------------------------------------------------------------------
  function automatic cpi_res_t lookup_color(logic [23:0] rgb, logic last);
    cpi_res_t res;
    bit       hit;
    res = '0;
    hit = 1'b0;
    for (int k = 0; k < pal_used; k++) begin
      if (!hit && pal_mem[k] == rgb) begin
        res.index = 8'(k);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (pal_used < DEPTH) begin
        pal_mem[pal_used] = rgb;
        res.index = 8'(pal_used);
        res.new_color = 1'b1;
        pal_used++;
      end else begin
        // no room: index 0, count unchanged
        res.full = 1'b1;
      end
    end
    res.used = 9'(pal_used);
    if (last) pal_used = 0;
    return res;
  endfunction

  // channel values lean on 00 and FF so the extremes turn up often
  function automatic logic [23:0] rand_color();
    logic [23:0] rgb;
    rgb = 24'($urandom);
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 7))
        0:       rgb[ch*8 +: 8] = 8'h00;
        1:       rgb[ch*8 +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return rgb;
  endfunction

  task automatic push_px(logic [23:0] rgb, logic last, bit drain);
    pixel_t px;
    px.red   = rgb[23:16];
    px.green = rgb[15:8];
    px.blue  = rgb[7:0];
    px.last  = last;
    px.drain = drain;
    pending_q.push_back(px);
    pushed++;
    if (last) n_images++;
  endtask

  // 256 distinct colors (red byte = insertion order, so no accidental hits)
  // with repeats mixed in, then a tail of misses and hits on the full palette.
  task automatic fill_to_overflow();
    logic [23:0] seen [DEPTH];
    logic [23:0] rgb;
    int          k;
    k = 0;
    push_px(24'h000000, 1'b0, 1'b1);
    seen[0] = 24'h000000;
    k = 1;
    while (k < DEPTH) begin
      if ($urandom_range(0, 3) == 0) begin
        push_px(seen[$urandom_range(0, k - 1)], 1'b0, 1'b0);
      end else begin
        rgb = (k == DEPTH - 1) ? 24'hFFFFFF : {8'(k), 16'($urandom)};
        seen[k] = rgb;
        push_px(rgb, 1'b0, 1'b0);
        k++;
      end
    end
    for (int j = 0; j < 24; j++) begin
      if ($urandom_range(0, 1)) rgb = seen[$urandom_range(0, DEPTH - 1)];
      else                      rgb = 24'($urandom);
      push_px(rgb, j == 23, 1'b0);
    end
  endtask

  task automatic flag_mismatch(string field, int got, int want);
    $display("[%0t] result %0d: %s got %0d, want %0d", $realtime, n_results, field, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: every accepted pixel runs through the model right away.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cpi_res_t res;
    px_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      res = lookup_color({in_red, in_green, in_blue}, in_last_pixel);
      due_q.push_back(res);
      n_pixels++;
      if (res.new_color)  n_new++;
      else if (res.full)  n_full++;
      else                n_hits++;
      if (int'(res.used) > peak_used) peak_used = int'(res.used);
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: compare each accepted word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cpi_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (due_q.size() == 0) begin
        flag_mismatch("unexpected word, palette_index", int'(out_palette_index), -1);
      end else begin
        want = due_q.pop_front();
        if (out_palette_index !== want.index)
          flag_mismatch("palette_index", int'(out_palette_index), int'(want.index));
        if (out_new_color !== want.new_color)
          flag_mismatch("new_color", int'(out_new_color), int'(want.new_color));
        if (out_palette_full !== want.full)
          flag_mismatch("palette_full", int'(out_palette_full), int'(want.full));
        if (out_colors_used !== want.used)
          flag_mismatch("colors_used", int'(out_colors_used), int'(want.used));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of words separated by random gaps. A stalled word is held.
  // A pixel marked drain is held back until every result is in.
  // ---------------------------------------------------------------------------
  int burst_left = 8;
  int gap_left   = 0;

  always @(negedge clk) begin
    pixel_t px;
    if (!rst_n) begin
      // idle through reset
    end else if (in_valid && !px_taken) begin
      // stalled: word stays put
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_q.size() == 0 || (pending_q[0].drain && due_q.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      px = pending_q.pop_front();
      in_red        <= px.red;
      in_green      <= px.green;
      in_blue       <= px.blue;
      in_last_pixel <= px.last;
      in_valid      <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0:       gap_left = 0;
          1:       gap_left = $urandom_range(1, 4);
          2:       gap_left = $urandom_range(5, 40);
          default: gap_left = $urandom_range(41, 300);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between none, per-cycle random and long
  // runs, each mode held for a while.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 300;
  int stall_run  = 0;

  always @(negedge clk) begin
    if (mode_left > 0) begin
      mode_left--;
    end else begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(500, 5000);
    end
    if (stall_run > 0) stall_run--;
    else if (stall_mode == 2 && $urandom_range(0, 15) == 0) stall_run = $urandom_range(1, 40);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (stall_run > 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [23:0] pool [16];
    logic [23:0] rgb;
    int          ncol;
    int          len;
    bit          shut;
    bit          second_fill;
    second_fill = 1'b0;

    // directed: extremes, hits, single-channel colors, last pixel on a hit,
    // on a miss and as a one-pixel image
    push_px(24'h000000, 1'b0, 1'b0);
    push_px(24'hFFFFFF, 1'b0, 1'b0);
    push_px(24'h000000, 1'b0, 1'b0);
    push_px(24'hFFFFFF, 1'b0, 1'b0);
    push_px(24'hFF0000, 1'b0, 1'b0);
    push_px(24'h00FF00, 1'b0, 1'b0);
    push_px(24'h0000FF, 1'b0, 1'b0);
    push_px(24'hAA55AA, 1'b0, 1'b0);
    push_px(24'h55AA55, 1'b0, 1'b0);
    push_px(24'hFF0000, 1'b0, 1'b0);
    push_px(24'hFFFFFF, 1'b1, 1'b0);   // last pixel that hits
    push_px(24'hFFFFFF, 1'b0, 1'b1);   // fresh palette: new again at index 0
    push_px(24'h000000, 1'b1, 1'b0);   // last pixel that misses
    push_px(24'h123456, 1'b1, 1'b0);   // one-pixel images
    push_px(24'h123456, 1'b1, 1'b0);
    push_px(24'h7F8001, 1'b0, 1'b0);
    push_px(24'h7F8001, 1'b1, 1'b0);

    // palette overflow once up front, again halfway through
    fill_to_overflow();

    while (pushed < TOTAL_PIXELS) begin
      if (!second_fill && pushed > TOTAL_PIXELS / 2) begin
        second_fill = 1'b1;
        fill_to_overflow();
      end else begin
        ncol = $urandom_range(1, 16);
        for (int c = 0; c < ncol; c++) pool[c] = rand_color();
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 30);
        // now and then an image runs on into the next without a last pixel
        shut = ($urandom_range(0, 9) != 0);
        for (int p = 0; p < len; p++) begin
          if ($urandom_range(0, 7) == 0) rgb = rand_color();
          else                           rgb = pool[$urandom_range(0, ncol - 1)];
          push_px(rgb, (shut && p == len - 1) || ($urandom_range(0, 39) == 0),
                  p == 0 && $urandom_range(0, 11) == 0);
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d pixels in %0d images, %0d results checked", n_pixels, n_images, n_results);
    $display("%0d hits, %0d new colors, %0d misses on a full palette, peak %0d entries",
             n_hits, n_new, n_full, peak_used);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
